[rtl/lst_pkg.sv]
`timescale 1ns / 1ps
// lst_pkg: shared widths, codes and control structs of the latency statistics tracker
// no dependencies

package lst_pkg;

   localparam int STAT_W = 32;
   localparam int LAT_W  = 16;
   localparam int MEAN_W = 24;
   localparam int SLOT_W = 6;
   localparam int PROD_W = STAT_W + MEAN_W;
   localparam int FRAC_W = 8;

   localparam logic [STAT_W-1:0] STAT_SAT = '1;

   localparam logic ACT_RECORD = 1'b0;
   localparam logic ACT_READ   = 1'b1;

   typedef struct packed {
      logic wr_en;
      logic rd_start;
   } lst_ring_cmd_type;

   typedef struct packed {
      logic rd_done;
   } lst_ring_sts_type;

endpackage

[rtl/lst_mean_unit.sv]
`timescale 1ns / 1ps
// lst_mean_unit: bit-serial mean update, shift-add multiply then restoring divide
// depends on lst_pkg

module lst_mean_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lst_pkg::MEAN_W-1:0]    mean_old,
   input  logic [lst_pkg::STAT_W-1:0]    count,
   input  logic [lst_pkg::LAT_W-1:0]     latency,
   output logic                          done,
   output logic [lst_pkg::MEAN_W-1:0]    mean_new
);
   import lst_pkg::*;

   localparam int CNT_W = $clog2(MEAN_W);

   typedef enum logic [1:0] {
      M_IDLE,
      M_MUL,
      M_ADD,
      M_DIV
   } mean_state_type;

   mean_state_type           state_ff, state_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [STAT_W-1:0]        mcand_ff, mcand_in;
   logic [STAT_W-1:0]        div_ff, div_in;
   logic [MEAN_W-1:0]        mplier_ff, mplier_in;
   logic [LAT_W-1:0]         lat_ff, lat_in;
   logic [PROD_W-1:0]        acc_ff, acc_in;
   logic [STAT_W-1:0]        rem_ff, rem_in;
   logic [MEAN_W-1:0]        dvd_ff, dvd_in;
   logic                     done_ff, done_in;
   logic [STAT_W:0]          trial;
   logic [STAT_W:0]          diff;
   logic                     ge;
   logic [PROD_W-1:0]        num;

   // one quotient digit per cycle
   assign trial = {rem_ff, dvd_ff[MEAN_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = (trial >= {1'b0, div_ff});
   assign num   = acc_ff + {{(PROD_W-LAT_W-FRAC_W){1'b0}}, lat_ff, {FRAC_W{1'b0}}};

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      div_in    = div_ff;
      mplier_in = mplier_ff;
      lat_in    = lat_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      done_in   = 1'b0;
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               mcand_in  = count - STAT_W'(1);
               div_in    = count;
               mplier_in = mean_old;
               lat_in    = latency;
               acc_in    = '0;
               cnt_in    = '0;
               state_in  = M_MUL;
            end
         end
         M_MUL: begin
            acc_in    = {acc_ff[PROD_W-2:0], 1'b0}
                        + (mplier_ff[MEAN_W-1] ? {{(PROD_W-STAT_W){1'b0}}, mcand_ff}
                                               : {PROD_W{1'b0}});
            mplier_in = {mplier_ff[MEAN_W-2:0], 1'b0};
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MEAN_W-1)) begin
               state_in = M_ADD;
            end
         end
         M_ADD: begin
            // quotient fits the mean width, so the upper STAT_W bits start as the remainder
            rem_in   = num[PROD_W-1:MEAN_W];
            dvd_in   = num[MEAN_W-1:0];
            cnt_in   = '0;
            state_in = M_DIV;
         end
         M_DIV: begin
            rem_in = ge ? diff[STAT_W-1:0] : trial[STAT_W-1:0];
            dvd_in = {dvd_ff[MEAN_W-2:0], ge};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MEAN_W-1)) begin
               done_in  = 1'b1;
               state_in = M_IDLE;
            end
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      mcand_ff  <= mcand_in;
      div_ff    <= div_in;
      mplier_ff <= mplier_in;
      lat_ff    <= lat_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
   end

   assign done     = done_ff;
   assign mean_new = dvd_ff;

endmodule

[rtl/lst_ring.sv]
`timescale 1ns / 1ps
// lst_ring: history ring memory with write pointer, wrap flag and serial slot reduction
// depends on lst_pkg

module lst_ring #(
   parameter int HISTORY_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lst_pkg::lst_ring_cmd_type     cmd,
   input  logic [lst_pkg::LAT_W-1:0]     wr_data,
   input  logic [lst_pkg::SLOT_W-1:0]    slot,
   output lst_pkg::lst_ring_sts_type     sts,
   output logic [lst_pkg::LAT_W-1:0]     rd_data
);
   import lst_pkg::*;

   localparam int PW = $clog2(HISTORY_DEPTH);
   localparam int SW = ((PW > SLOT_W) ? PW : SLOT_W) + 1;

   typedef enum logic [1:0] {
      R_IDLE,
      R_REDUCE,
      R_FETCH
   } ring_state_type;

   ring_state_type      state_ff, state_in;
   logic [PW-1:0]       ptr_ff, ptr_in;
   logic                wrap_ff, wrap_in;
   logic [SW-1:0]       pos_ff, pos_in;
   logic                vld_ff, vld_in;
   logic                done_ff, done_in;
   logic [LAT_W-1:0]    mem [HISTORY_DEPTH];
   logic [LAT_W-1:0]    raw_ff;

   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      wrap_in  = wrap_ff;
      pos_in   = pos_ff;
      vld_in   = vld_ff;
      done_in  = 1'b0;
      if (cmd.wr_en) begin
         if (ptr_ff == PW'(HISTORY_DEPTH-1)) begin
            ptr_in  = '0;
            wrap_in = 1'b1;
         end else begin
            ptr_in = ptr_ff + PW'(1);
         end
      end
      case (state_ff)
         R_IDLE: begin
            if (cmd.rd_start) begin
               pos_in   = SW'(ptr_ff) + SW'(slot);
               state_in = R_REDUCE;
            end
         end
         R_REDUCE: begin
            if (pos_ff >= SW'(HISTORY_DEPTH)) begin
               pos_in = pos_ff - SW'(HISTORY_DEPTH);
            end else begin
               state_in = R_FETCH;
            end
         end
         R_FETCH: begin
            // entries never written since reset read as zero
            vld_in   = wrap_ff | (pos_ff[PW-1:0] < ptr_ff);
            done_in  = 1'b1;
            state_in = R_IDLE;
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         ptr_ff   <= '0;
         wrap_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         wrap_ff  <= wrap_in;
         done_ff  <= done_in;
      end
      pos_ff <= pos_in;
      vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[ptr_ff] <= wr_data;
      end
      if (state_ff == R_FETCH) begin
         raw_ff <= mem[pos_ff[PW-1:0]];
      end
   end

   assign sts.rd_done = done_ff;
   assign rd_data     = vld_ff ? raw_ff : '0;

endmodule

[rtl/latency_statistics_tracker_core.sv]
`timescale 1ns / 1ps
// latency_statistics_tracker_core: top level, control sequencer, statistics and result register
// depends on lst_pkg, lst_mean_unit, lst_ring

// Takes one beat per probe outcome or history read and returns one result beat carrying the
// updated statistics. One item is worked on at a time. For a successful probe, the mean update
// runs in a bit-serial unit that does a 24-step shift-add multiply, one add of the new
// latency and a 24-step restoring divide; the quotient is then handed over through a done
// register and loaded into the result register. A failed probe goes straight to the commit
// state. A history read reduces the slot position by serial wrap-around, subtracting the ring
// depth at most once when HISTORY_DEPTH is at least 64, then reads the registered memory. A
// result is held back while the previous one still waits untaken in the output register.
// The next request is taken as soon as the result is in the output register, before that
// result is taken. The ring reads as zero where it was never written; there is no clearing
// pass after reset.

module latency_statistics_tracker_core #(
   parameter int HISTORY_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic                          req_probe_ok,
   input  logic [lst_pkg::LAT_W-1:0]     req_round_trip,
   input  logic [lst_pkg::SLOT_W-1:0]    req_history_slot,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_online,
   output logic [lst_pkg::STAT_W-1:0]    rsp_probes_total,
   output logic [lst_pkg::STAT_W-1:0]    rsp_probes_good,
   output logic [lst_pkg::LAT_W-1:0]     rsp_last_latency,
   output logic [lst_pkg::LAT_W-1:0]     rsp_least_latency,
   output logic [lst_pkg::LAT_W-1:0]     rsp_greatest_latency,
   output logic [lst_pkg::MEAN_W-1:0]    rsp_mean_latency,
   output logic [lst_pkg::STAT_W-1:0]    rsp_good_run,
   output logic [lst_pkg::STAT_W-1:0]    rsp_bad_run,
   output logic [lst_pkg::LAT_W-1:0]     rsp_history_value
);
   import lst_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MEAN,
      S_READ,
      S_COMMIT
   } top_state_type;

   top_state_type       state_ff, state_in;
   logic                act_ff;
   logic                ok_ff;
   logic [LAT_W-1:0]    rt_ff;

   logic [STAT_W-1:0]   total_ff, total_in;
   logic [STAT_W-1:0]   good_ff, good_in;
   logic [LAT_W-1:0]    recent_ff, recent_in;
   logic                up_ff, up_in;
   logic [LAT_W-1:0]    low_ff, low_in;
   logic [LAT_W-1:0]    high_ff, high_in;
   logic [MEAN_W-1:0]   mean_ff, mean_in;
   logic [STAT_W-1:0]   srun_ff, srun_in;
   logic [STAT_W-1:0]   frun_ff, frun_in;
   logic                rsp_valid_ff;

   logic                accept;
   logic                commit;
   logic                recording;
   logic [STAT_W-1:0]   good_next;
   logic                mean_start;
   logic                mean_done;
   logic [MEAN_W-1:0]   mean_new;
   lst_ring_cmd_type    ring_cmd;
   lst_ring_sts_type    ring_sts;
   logic [LAT_W-1:0]    ring_data;

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid & req_ready;
   assign commit     = (state_ff == S_COMMIT) & (~rsp_valid_ff | rsp_ready);
   assign recording  = (act_ff == ACT_RECORD);
   assign good_next  = (good_ff == STAT_SAT) ? good_ff : good_ff + STAT_W'(1);
   assign mean_start = accept & (req_action == ACT_RECORD) & req_probe_ok;

   assign ring_cmd.wr_en    = commit & recording;
   assign ring_cmd.rd_start = accept & (req_action == ACT_READ);

   lst_mean_unit u_mean (
      .clock    (clock),
      .reset    (reset),
      .start    (mean_start),
      .mean_old (mean_ff),
      .count    (good_next),
      .latency  (req_round_trip),
      .done     (mean_done),
      .mean_new (mean_new)
   );

   lst_ring #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ring_cmd),
      .wr_data (recent_in),
      .slot    (req_history_slot),
      .sts     (ring_sts),
      .rd_data (ring_data)
   );

   // statistics after the current item
   always_comb begin
      total_in  = total_ff;
      good_in   = good_ff;
      recent_in = recent_ff;
      up_in     = up_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      mean_in   = mean_ff;
      srun_in   = srun_ff;
      frun_in   = frun_ff;
      if (recording) begin
         total_in = (total_ff == STAT_SAT) ? total_ff : total_ff + STAT_W'(1);
         if (ok_ff) begin
            good_in   = good_next;
            recent_in = rt_ff;
            up_in     = 1'b1;
            srun_in   = (srun_ff == STAT_SAT) ? srun_ff : srun_ff + STAT_W'(1);
            frun_in   = '0;
            if ((low_ff == '0) || (rt_ff < low_ff)) begin
               low_in = rt_ff;
            end
            if (rt_ff > high_ff) begin
               high_in = rt_ff;
            end
            mean_in = mean_new;
         end else begin
            recent_in = '0;
            up_in     = 1'b0;
            frun_in   = (frun_ff == STAT_SAT) ? frun_ff : frun_ff + STAT_W'(1);
            srun_in   = '0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_action == ACT_READ) begin
                  state_in = S_READ;
               end else if (req_probe_ok) begin
                  state_in = S_MEAN;
               end else begin
                  state_in = S_COMMIT;
               end
            end
         end
         S_MEAN: begin
            if (mean_done) begin
               state_in = S_COMMIT;
            end
         end
         S_READ: begin
            if (ring_sts.rd_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         good_ff      <= '0;
         recent_ff    <= '0;
         up_ff        <= 1'b0;
         low_ff       <= '0;
         high_ff      <= '0;
         mean_ff      <= '0;
         srun_ff      <= '0;
         frun_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
            total_ff     <= total_in;
            good_ff      <= good_in;
            recent_ff    <= recent_in;
            up_ff        <= up_in;
            low_ff       <= low_in;
            high_ff      <= high_in;
            mean_ff      <= mean_in;
            srun_ff      <= srun_in;
            frun_ff      <= frun_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         act_ff <= req_action;
         ok_ff  <= req_probe_ok;
         rt_ff  <= req_round_trip;
      end
      // result beat
      if (commit) begin
         rsp_online           <= up_in;
         rsp_probes_total     <= total_in;
         rsp_probes_good      <= good_in;
         rsp_last_latency     <= recent_in;
         rsp_least_latency    <= low_in;
         rsp_greatest_latency <= high_in;
         rsp_mean_latency     <= mean_in;
         rsp_good_run         <= srun_in;
         rsp_bad_run          <= frun_in;
         rsp_history_value    <= recording ? '0 : ring_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/lst_checker.sv]
`timescale 1ns / 1ps
// lst_checker: port-level checks on the latency statistics tracker, bound to the top level
// depends on lst_pkg and latency_statistics_tracker_core

module lst_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_action,
   input  logic                          req_probe_ok,
   input  logic [lst_pkg::LAT_W-1:0]     req_round_trip,
   input  logic [lst_pkg::SLOT_W-1:0]    req_history_slot,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic                          rsp_online,
   input  logic [lst_pkg::STAT_W-1:0]    rsp_probes_total,
   input  logic [lst_pkg::STAT_W-1:0]    rsp_probes_good,
   input  logic [lst_pkg::LAT_W-1:0]     rsp_last_latency,
   input  logic [lst_pkg::LAT_W-1:0]     rsp_least_latency,
   input  logic [lst_pkg::LAT_W-1:0]     rsp_greatest_latency,
   input  logic [lst_pkg::MEAN_W-1:0]    rsp_mean_latency,
   input  logic [lst_pkg::STAT_W-1:0]    rsp_good_run,
   input  logic [lst_pkg::STAT_W-1:0]    rsp_bad_run,
   input  logic [lst_pkg::LAT_W-1:0]     rsp_history_value
);
   import lst_pkg::*;

   // a stalled result beat stays valid and keeps its total count and mean
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_probes_total)
                                  && $stable(rsp_mean_latency))
      else $error("result beat changed while stalled");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in flight");

   a_good_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_probes_good <= rsp_probes_total)
      else $error("good count above total count");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_least_latency <= rsp_greatest_latency)
      else $error("least latency above greatest latency");

   a_online_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_online == (rsp_good_run != '0))
      else $error("online flag disagrees with success run");

endmodule

bind latency_statistics_tracker_core lst_checker u_lst_checker (.*);
